@@ rtl/msp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the metal site pose error pipeline.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int IDX_W     = 6;
    localparam int AXIS_W    = 16;
    localparam int SHIFT_W   = 24;
    localparam int RAD_W     = 16;
    localparam int ERR_W     = 24;

    localparam int MaxSites  = 64;

    localparam int FRAC_BITS = 30;
    localparam int SINE_W    = FRAC_BITS + 1;   // Q1.30 value in [0, 2^30]
    localparam int SQ_W      = 33;              // square of a 17-bit signed value
    localparam int PQ_W      = 34;              // sum of up to three squares
    localparam int T2_W      = 48;              // squared translation, Q.16
    localparam int RAD2_W    = 2 * RAD_W;
    localparam int PROD_W    = RAD2_W + SINE_W;

    // cycles from the input register to the registered sine value
    localparam int SINE_LAT  = 4 + FRAC_BITS;
    // cycles of the square root pipeline, one result bit per stage
    localparam int SQRT_LAT  = ERR_W;
    // accepted transaction to result strobe: input register, sine, min,
    // scale, sum, square root and output register
    localparam int PIPE_LAT  = SINE_LAT + SQRT_LAT + 5;

    localparam logic [RAD_W-1:0]  RAD_RESET  = 16'd512;
    localparam logic [RAD2_W-1:0] RAD2_RESET = 32'd262144;
    localparam logic [ERR_W-1:0]  NO_PAIR    = 24'hFFFFFF;
    localparam logic [ERR_W-1:0]  ERR_MAX    = 24'hFFFFFE;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } side_t;

endpackage

`default_nettype wire

@@ rtl/msp_delay.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msp_delay
// Fixed-depth shift line carrying a valid bit alongside its payload.
// ----------------------------------------------------------------------------
module msp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    output logic [WIDTH-1:0]      out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/msp_sine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msp_sine
// Squared sine of the angle between z+y (or z-y) and the z direction:
// axis sum or difference, squares, p and q, then a restoring divider with
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module msp_sine
    import msp_pkg::*;
#(
    parameter bit SUBTRACT = 1'b0
) (
    input  wire logic                     clk,
    input  wire logic signed [AXIS_W-1:0] y_x,
    input  wire logic signed [AXIS_W-1:0] y_y,
    input  wire logic signed [AXIS_W-1:0] y_z,
    input  wire logic signed [AXIS_W-1:0] z_x,
    input  wire logic signed [AXIS_W-1:0] z_y,
    input  wire logic signed [AXIS_W-1:0] z_z,
    output logic [SINE_W-1:0]             sine_sq
);

    logic signed [AXIS_W:0]  ax_reg, ay_reg, az_reg;
    logic signed [AXIS_W:0]  ax_next, ay_next, az_next;
    logic signed [2*AXIS_W+1:0] px, py, pz;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic [PQ_W-1:0]         p_reg, q_reg;

    logic [PQ_W-1:0]   rem_reg  [FRAC_BITS+1];
    logic [PQ_W-1:0]   den_reg  [FRAC_BITS+1];
    logic [SINE_W-1:0] quo_reg  [FRAC_BITS+1];
    logic              zero_reg [FRAC_BITS+1];

    always_comb
    begin
        if (SUBTRACT)
        begin
            ax_next = {z_x[AXIS_W-1], z_x} - {y_x[AXIS_W-1], y_x};
            ay_next = {z_y[AXIS_W-1], z_y} - {y_y[AXIS_W-1], y_y};
            az_next = {z_z[AXIS_W-1], z_z} - {y_z[AXIS_W-1], y_z};
        end
        else
        begin
            ax_next = {z_x[AXIS_W-1], z_x} + {y_x[AXIS_W-1], y_x};
            ay_next = {z_y[AXIS_W-1], z_y} + {y_y[AXIS_W-1], y_y};
            az_next = {z_z[AXIS_W-1], z_z} + {y_z[AXIS_W-1], y_z};
        end
    end

    assign px = ax_reg * ax_reg;
    assign py = ay_reg * ay_reg;
    assign pz = az_reg * az_reg;

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        sqx_reg <= px[SQ_W-1:0];
        sqy_reg <= py[SQ_W-1:0];
        sqz_reg <= pz[SQ_W-1:0];
        p_reg   <= PQ_W'(sqx_reg) + PQ_W'(sqy_reg);
        q_reg   <= PQ_W'(sqx_reg) + PQ_W'(sqy_reg) + PQ_W'(sqz_reg);
        // integer quotient bit: p never exceeds q
        rem_reg[0]  <= (p_reg >= q_reg) ? p_reg - q_reg : p_reg;
        quo_reg[0]  <= SINE_W'(p_reg >= q_reg);
        den_reg[0]  <= q_reg;
        zero_reg[0] <= (q_reg == '0);
    end

    for (genvar k = 1; k <= FRAC_BITS; k++)
    begin : g_div
        logic [PQ_W:0] trial;
        logic          ge;

        assign trial = {rem_reg[k-1], 1'b0};
        assign ge    = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? PQ_W'(trial - {1'b0, den_reg[k-1]}) : trial[PQ_W-1:0];
            quo_reg[k]  <= {quo_reg[k-1][SINE_W-2:0], ge};
            den_reg[k]  <= den_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
        end
    end

    // zero-length axis: sine is one
    assign sine_sq = zero_reg[FRAC_BITS] ? SINE_W'(1) << FRAC_BITS : quo_reg[FRAC_BITS];

endmodule

`default_nettype wire

@@ rtl/msp_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module msp_sqrt
    import msp_pkg::*;
(
    input  wire logic            clk,
    input  wire logic [T2_W-1:0] radicand,
    output logic [ERR_W-1:0]     root
);

    localparam int REM_W = ERR_W + 1;

    logic [T2_W-1:0]  x_reg    [SQRT_LAT];
    logic [REM_W-1:0] rem_reg  [SQRT_LAT];
    logic [ERR_W-1:0] root_reg [SQRT_LAT];

    for (genvar i = 0; i < SQRT_LAT; i++)
    begin : g_stage
        logic [T2_W-1:0]  x_in;
        logic [REM_W-1:0] rem_in;
        logic [ERR_W-1:0] root_in;
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign x_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign x_in    = x_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        assign rem_sh = {rem_in, x_in[T2_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            x_reg[i]    <= {x_in[T2_W-3:0], 2'b00};
            rem_reg[i]  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
            root_reg[i] <= {root_in[ERR_W-2:0], ge};
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

`default_nettype wire

@@ rtl/metal_site_pose_error_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// metal_site_pose_error_top
// Pose error of one metal site pair per transaction.
// ----------------------------------------------------------------------------
// The block takes one site pair in every clock cycle (busy stays low) and
// returns its result on a one-cycle done strobe; results leave in the order
// their transactions came in. The result passes through the input register,
// the two 31-stage restoring dividers (after their axis, square and sum
// stages) that form the squared sines, three stages for min, scale and
// sum, the 24-stage square root, each retiring one bit per stage, and the
// output register. The receiver cannot stall, so nothing holds the pipeline.
// site_radius is written over the cfg port (cfg_ready stays high) and must
// only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module metal_site_pose_error_top
    import msp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [RAD_W-1:0]          cfg_data,
    input  wire logic [IDX_W-1:0]          row_index,
    input  wire logic [IDX_W-1:0]          col_index,
    input  wire logic                      pair_matched,
    input  wire logic signed [AXIS_W-1:0]  yaxis_x,
    input  wire logic signed [AXIS_W-1:0]  yaxis_y,
    input  wire logic signed [AXIS_W-1:0]  yaxis_z,
    input  wire logic signed [AXIS_W-1:0]  zaxis_x,
    input  wire logic signed [AXIS_W-1:0]  zaxis_y,
    input  wire logic signed [AXIS_W-1:0]  zaxis_z,
    input  wire logic signed [SHIFT_W-1:0] shift_x,
    input  wire logic signed [SHIFT_W-1:0] shift_y,
    output logic                           done,
    output logic [ERR_W-1:0]               pair_error,
    output logic [IDX_W-1:0]               out_row,
    output logic [IDX_W-1:0]               out_col
);

    logic                      accept;
    logic [RAD2_W-1:0]         rad2_reg;

    logic                      v0_reg, v1_reg, v2_reg;
    side_t                     side0_reg, side1_reg, side2_reg;
    logic signed [AXIS_W-1:0]  yx_reg, yy_reg, yz_reg, zx_reg, zy_reg, zz_reg;
    logic signed [SHIFT_W-1:0] sx_reg, sy_reg;
    logic signed [2*SHIFT_W-1:0] sxp, syp;
    logic [T2_W-2:0]           sxsq_reg, sysq_reg;
    logic [T2_W-1:0]           t2_reg;

    logic                      vd;
    side_t                     side_d;
    logic [T2_W-1:0]           t2_d;

    logic [SINE_W-1:0]         s_pos, s_neg;

    logic                      v35_reg, v36_reg, v37_reg;
    side_t                     side35_reg, side36_reg, side37_reg;
    logic [T2_W-1:0]           t2_35_reg, t2_36_reg;
    logic [SINE_W-1:0]         smin_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [T2_W-1:0]           total_reg;

    logic [ERR_W-1:0]          root;
    logic                      vq;
    side_t                     side_q;

    logic                      done_reg;
    logic [ERR_W-1:0]          err_reg;
    logic [IDX_W-1:0]          row_reg, col_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // squared radius; the user must only change it while the pipeline is empty (unenforced)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad2_reg <= RAD2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rad2_reg <= cfg_data * cfg_data;
        end
    end

    // valid bits of the front and back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v35_reg  <= 1'b0;
            v36_reg  <= 1'b0;
            v37_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v35_reg  <= vd;
            v36_reg  <= v35_reg;
            v37_reg  <= v36_reg;
            done_reg <= vq;
        end
    end

    assign sxp = sx_reg * sx_reg;
    assign syp = sy_reg * sy_reg;

    // capture the transaction and build the lateral term
    always_ff @(posedge clk)
    begin
        side0_reg.hit <= pair_matched && (row_index == col_index)
                         && (11'(row_index) < 11'(MaxSites));
        side0_reg.row <= row_index;
        side0_reg.col <= col_index;
        yx_reg    <= yaxis_x;
        yy_reg    <= yaxis_y;
        yz_reg    <= yaxis_z;
        zx_reg    <= zaxis_x;
        zy_reg    <= zaxis_y;
        zz_reg    <= zaxis_z;
        sx_reg    <= shift_x;
        sy_reg    <= shift_y;
        side1_reg <= side0_reg;
        sxsq_reg  <= sxp[T2_W-2:0];
        sysq_reg  <= syp[T2_W-2:0];
        side2_reg <= side1_reg;
        t2_reg    <= T2_W'(sxsq_reg) + T2_W'(sysq_reg);
    end

    msp_sine #(
        .SUBTRACT (1'b0)
    ) u_sine_pos (
        .clk     (clk),
        .y_x     (yx_reg),
        .y_y     (yy_reg),
        .y_z     (yz_reg),
        .z_x     (zx_reg),
        .z_y     (zy_reg),
        .z_z     (zz_reg),
        .sine_sq (s_pos)
    );

    msp_sine #(
        .SUBTRACT (1'b1)
    ) u_sine_neg (
        .clk     (clk),
        .y_x     (yx_reg),
        .y_y     (yy_reg),
        .y_z     (yz_reg),
        .z_x     (zx_reg),
        .z_y     (zy_reg),
        .z_z     (zz_reg),
        .sine_sq (s_neg)
    );

    // carry indices and lateral term alongside the dividers
    msp_delay #(
        .WIDTH ($bits(side_t) + T2_W),
        .DEPTH (SINE_LAT - 2)
    ) u_delay_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_data   ({side2_reg, t2_reg}),
        .out_valid (vd),
        .out_data  ({side_d, t2_d})
    );

    // keep the smaller sine, scale by radius squared, add the lateral term
    always_ff @(posedge clk)
    begin
        side35_reg <= side_d;
        t2_35_reg  <= t2_d;
        smin_reg   <= (s_pos < s_neg) ? s_pos : s_neg;
        side36_reg <= side35_reg;
        t2_36_reg  <= t2_35_reg;
        prod_reg   <= rad2_reg * smin_reg;
        side37_reg <= side36_reg;
        total_reg  <= t2_36_reg + T2_W'(prod_reg[PROD_W-1:FRAC_BITS]);
    end

    msp_sqrt u_sqrt (
        .clk      (clk),
        .radicand (total_reg),
        .root     (root)
    );

    msp_delay #(
        .WIDTH ($bits(side_t)),
        .DEPTH (SQRT_LAT)
    ) u_delay_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v37_reg),
        .in_data   (side37_reg),
        .out_valid (vq),
        .out_data  (side_q)
    );

    // mark pairs that are no hit with the no-pair value, saturate large errors one below it
    always_ff @(posedge clk)
    begin
        if (!side_q.hit)
        begin
            err_reg <= NO_PAIR;
        end
        else if (root == NO_PAIR)
        begin
            err_reg <= ERR_MAX;
        end
        else
        begin
            err_reg <= root;
        end
        row_reg <= side_q.row;
        col_reg <= side_q.col;
    end

    assign done       = done_reg;
    assign pair_error = err_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;

`ifndef SYNTH
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LAT done)
        else $error("transaction did not complete after the pipeline latency");

    a_offdiag : assert property (@(posedge clk) disable iff (!rst_n)
        done && (out_row != out_col) |-> pair_error == NO_PAIR)
        else $error("off-diagonal pair returned an error value");

    a_unused : assert property (@(posedge clk) disable iff (!rst_n)
        !v0_reg |-> ##(PIPE_LAT - 1) !done)
        else $error("result strobe without a transaction");
`endif

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks each pair error result of the metal site pose error block against an
// in-bench fixed-point predictor: a table of directed site pairs first, then
// random pairs sent in bursts, with the site radius changed between phases.
// ----------------------------------------------------------------------------
module testbench
    import msp_pkg::*;
();

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 1450;
    localparam int  N_TABLE     = 20;

    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic                      matched;
        logic signed [AXIS_W-1:0]  yx, yy, yz, zx, zy, zz;
        logic signed [SHIFT_W-1:0] tx, ty;
    } site_pair_t;

    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } pose_result_t;

    // one directed row: the pair, plus a typed-in error where it is obvious
    typedef struct packed {
        site_pair_t       pair;
        logic             known;
        logic [ERR_W-1:0] err;
    } pair_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_valid;
    logic cfg_ready;
    logic [RAD_W-1:0] cfg_data;
    site_pair_t pair_in;
    logic done;
    logic [ERR_W-1:0] pair_error;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;

    pose_result_t pending_poses[$];
    logic [RAD_W-1:0] radius_model;
    int mismatches;
    int cycles;
    pair_row_t pair_table[N_TABLE];

    metal_site_pose_error_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .row_index    (pair_in.row),
        .col_index    (pair_in.col),
        .pair_matched (pair_in.matched),
        .yaxis_x      (pair_in.yx),
        .yaxis_y      (pair_in.yy),
        .yaxis_z      (pair_in.yz),
        .zaxis_x      (pair_in.zx),
        .zaxis_y      (pair_in.zy),
        .zaxis_z      (pair_in.zz),
        .shift_x      (pair_in.tx),
        .shift_y      (pair_in.ty),
        .done         (done),
        .pair_error   (pair_error),
        .out_row      (out_row),
        .out_col      (out_col)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Squared sine of the angle between an axis and z, Q1.30; a zero-length
    // axis counts as perpendicular.
    function automatic longint unsigned axis_sine_sq(longint ax, longint ay, longint az);
        longint unsigned p;
        longint unsigned q;
        p = longint'(ax * ax) + longint'(ay * ay);
        q = p + longint'(az * az);
        if (q == 0)
            return 64'd1 << FRAC_BITS;
        return (p << FRAC_BITS) / q;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            b = r | (64'd1 << i);
            if (b * b <= x)
                r = b;
        end
        return r;
    endfunction

    function automatic pose_result_t predict_pose(site_pair_t s, logic [RAD_W-1:0] radius);
        pose_result_t res;
        longint unsigned s_plus;
        longint unsigned s_minus;
        longint unsigned s_min;
        longint unsigned total;
        longint unsigned root_val;
        longint tx;
        longint ty;
        res.row = s.row;
        res.col = s.col;
        res.err = NO_PAIR;
        if (s.matched && s.row == s.col)
        begin
            s_plus  = axis_sine_sq(longint'(s.zx) + s.yx, longint'(s.zy) + s.yy,
                                   longint'(s.zz) + s.yz);
            s_minus = axis_sine_sq(longint'(s.zx) - s.yx, longint'(s.zy) - s.yy,
                                   longint'(s.zz) - s.yz);
            s_min = (s_plus < s_minus) ? s_plus : s_minus;
            tx = s.tx;
            ty = s.ty;
            total = longint'(tx * tx) + longint'(ty * ty)
                  + ((longint'(radius) * radius * s_min) >> FRAC_BITS);
            root_val = floor_sqrt(total);
            res.err = (root_val >= NO_PAIR) ? ERR_MAX : root_val[ERR_W-1:0];
        end
        return res;
    endfunction

    function automatic site_pair_t random_pair();
        site_pair_t s;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        s = raw[$bits(site_pair_t)-1:0];
        // mostly diagonal matched pairs: those are the ones that get computed
        if ($urandom_range(0, 9) < 8)
        begin
            s.col = s.row;
            s.matched = 1'b1;
        end
        // often shrink the shift so the rotation term shows in the result
        if ($urandom_range(0, 2) == 0)
        begin
            s.tx = $signed(s.tx) >>> $urandom_range(0, 23);
            s.ty = $signed(s.ty) >>> $urandom_range(0, 23);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            s.yx = '0; s.yy = '0; s.yz = '0;
        end
        return s;
    endfunction

    function automatic pair_row_t mk_row(site_pair_t s, int known, logic [ERR_W-1:0] e);
        pair_row_t r;
        r.pair = s;
        r.known = (known != 0);
        r.err = e;
        return r;
    endfunction

    function automatic site_pair_t mk_pair(int r, int c, int m, int yx, int yy, int yz,
                                           int zx, int zy, int zz, int tx, int ty);
        site_pair_t s;
        s.row = IDX_W'(r); s.col = IDX_W'(c); s.matched = (m != 0);
        s.yx = AXIS_W'(yx); s.yy = AXIS_W'(yy); s.yz = AXIS_W'(yz);
        s.zx = AXIS_W'(zx); s.zy = AXIS_W'(zy); s.zz = AXIS_W'(zz);
        s.tx = SHIFT_W'(tx); s.ty = SHIFT_W'(ty);
        return s;
    endfunction

    // Check every result strobe against the oldest pending prediction.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result err=%h row=%0d col=%0d",
                             pair_error, out_row, out_col);
            end
            else
            begin
                pose_result_t want;
                want = pending_poses.pop_front();
                if (want.err !== pair_error || want.row !== out_row
                    || want.col !== out_col)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want err=%h row=%0d col=%0d, got %h %0d %0d",
                                 want.err, want.row, want.col,
                                 pair_error, out_row, out_col);
                end
            end
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Present one pair and hold it until a transaction happens; start stays high.
    task automatic send_pair(site_pair_t s, pose_result_t want);
        pair_in <= s;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        pending_poses.push_back(want);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drain the pipeline, then write the radius.
    task automatic write_radius(logic [RAD_W-1:0] value);
        idle_cycles(1);
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_model = value;
    endtask

    initial
    begin
        int burst;
        pose_result_t want;
        logic [RAD_W-1:0] radius_steps[5];

        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        pair_in = '0;
        mismatches = 0;
        cycles = 0;
        radius_model = RAD_RESET;

        // Directed rows: index extremes, unmatched and off-diagonal pairs,
        // zero-length axes, axis extremes, largest errors and shift-only errors.
        pair_table[0]  = mk_row(mk_pair(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 24'd512);
        pair_table[1]  = mk_row(mk_pair(63, 63, 1, 0, 0, 0, 0, 0, 16384, 0, 0), 1, 24'd0);
        pair_table[2]  = mk_row(mk_pair(5, 5, 0, 1, 2, 3, 4, 5, 6, 7, 8), 1, NO_PAIR);
        pair_table[3]  = mk_row(mk_pair(0, 63, 1, 0, 0, 0, 0, 0, 16384, 0, 0), 1, NO_PAIR);
        pair_table[4]  = mk_row(mk_pair(63, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, NO_PAIR);
        pair_table[5]  = mk_row(mk_pair(1, 1, 1, 0, 0, 0, 0, 0, 0, 768, 1024), 0, '0);
        pair_table[6]  = mk_row(mk_pair(2, 2, 1, 0, 0, 0, 0, 0, 16384, 768, 1024), 1,
                                24'd1280);
        pair_table[7]  = mk_row(mk_pair(3, 3, 1, -32768, -32768, -32768, -32768, -32768,
                                        -32768, -8388608, -8388608), 0, '0);
        pair_table[8]  = mk_row(mk_pair(4, 4, 1, 32767, 32767, 32767, 32767, 32767,
                                        32767, 8388607, 8388607), 0, '0);
        pair_table[9]  = mk_row(mk_pair(6, 6, 1, 0, 16384, 0, 0, 0, 16384, 0, 0), 0, '0);
        pair_table[10] = mk_row(mk_pair(7, 7, 1, 16384, 0, 0, 16384, 0, 0, 0, 0), 1,
                                24'd512);
        pair_table[11] = mk_row(mk_pair(8, 8, 1, 11585, 0, 11585, 0, 11585, 11585, 0, 0),
                                0, '0);
        pair_table[12] = mk_row(mk_pair(9, 9, 1, -32768, 32767, -1, 32767, -32768, 0,
                                        -1, 1), 0, '0);
        pair_table[13] = mk_row(mk_pair(10, 10, 1, 0, 0, 0, 0, 0, 0, 8388607, 0), 1,
                                24'd8388607);
        pair_table[14] = mk_row(mk_pair(11, 11, 1, 0, 0, 16384, 0, 0, 16384, -8388608, 0),
                                1, 24'd8388608);
        pair_table[15] = mk_row(mk_pair(12, 12, 1, 0, 0, 0, 0, 0, 0, 8388607, 8388607),
                                0, '0);
        pair_table[16] = mk_row(mk_pair(33, 33, 1, 100, -200, 300, -400, 500, -600, 12345,
                                        -54321), 0, '0);
        pair_table[17] = mk_row(mk_pair(42, 21, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, NO_PAIR);
        pair_table[18] = mk_row(mk_pair(13, 13, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 24'd512);
        pair_table[19] = mk_row(mk_pair(14, 14, 1, 1, 0, 0, -1, 0, 0, 0, 0), 1, 24'd512);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed phase at the reset radius; typed-in rows are checked
        // against the predictor too, so a wrong table entry shows up here.
        foreach (pair_table[i])
        begin
            want = predict_pose(pair_table[i].pair, radius_model);
            if (pair_table[i].known && want.err !== pair_table[i].err)
                $display("table row %0d disagrees with predictor", i);
            if (pair_table[i].known)
                want.err = pair_table[i].err;
            send_pair(pair_table[i].pair, want);
        end

        // Random phases, one radius per phase, extremes included.
        radius_steps[0] = 16'h0000;
        radius_steps[1] = 16'hFFFF;
        radius_steps[2] = 16'd1;
        radius_steps[3] = 16'($urandom);
        radius_steps[4] = 16'd512;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_radius(radius_steps[phase]);
            for (int n = 0; n < N_RANDOM / 5; )
            begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++)
                begin
                    site_pair_t s;
                    s = random_pair();
                    send_pair(s, predict_pose(s, radius_model));
                end
                // hold off a random gap, sometimes none at all
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 70));
            end
        end

        idle_cycles(1);
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
